// ===== design/svo_pkg.sv =====
// shared types, constants and angle test for the octant shadowcasting block
package svo_pkg;

  localparam int MAX_RADIUS     = 16;
  localparam int INTERVAL_DEPTH = 256;
  localparam int IDX_W          = $clog2(INTERVAL_DEPTH);
  localparam int CNT_W          = IDX_W + 1;
  localparam int COORD_W        = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } svo_state_e;

  // one stored obstruction: the visible opaque cell that cast it
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } entry_t;

  // query walking down the chain, with the blocked flags gathered so far
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               sb;
    logic               eb;
    logic               cb;
  } token_t;

  // write port broadcast to every stage
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_t;

  // true if num/den lies in [ic/(ir+1), (ic+1)/(ir+1)], ends included
  function automatic logic in_span(input logic [5:0] num, input logic [5:0] den,
                                   input logic [COORD_W-1:0] ic,
                                   input logic [COORD_W-1:0] ir);
    logic [4:0]  k;
    logic [10:0] ns;
    logic [10:0] lo;
    logic [10:0] hi;
    k  = {1'b0, ir} + 5'd1;
    ns = 11'(num) * 11'(k);
    lo = 11'(ic) * 11'(den);
    hi = lo + 11'(den);
    return (ns >= lo) && (ns <= hi);
  endfunction

endpackage

// ===== design/shadowcast_visibility_octant.sv =====
// top level: octant shadowcasting visibility, one cell request at a time
//
//   channel   signals                                    direction
//   -------   ----------------------------------------   ---------
//   in        in_valid_i / in_ready_o, octant_start_i,    request in
//             row_i, column_i, transparent_i
//   out       out_valid_o / out_ready_i, visible_o        result out
//
// a request passes through three states: idle to take it, scan while the
// query walks the chain past each committed interval (entered also for the
// origin and an empty store), and finish to load the output register
// reset clears counters and handshake state, not the stored intervals
// a stalled output holds its result while the next request is scanned; the
// finish state then waits until the output drains
module shadowcast_visibility_octant import svo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               octant_start_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] column_i,
  input  logic               transparent_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(INTERVAL_DEPTH);

  svo_state_e state_q, state_d;

  // control registers
  logic [CNT_W-1:0]   comm_q, comm_d;    // intervals effective for this row
  logic [CNT_W-1:0]   total_q, total_d;  // intervals written, pending included
  logic [CNT_W-1:0]   lim_q, lim_d;      // intervals the current query must pass
  logic [CNT_W-1:0]   cnt_q, cnt_d;      // stages the query has passed
  logic [COORD_W-1:0] cur_q, cur_d;      // row of the latest cell in radius or at octant start
  logic               force_q, force_d;  // answer fixed without the scan
  logic               fvis_q, fvis_d;
  logic               out_valid_q, out_valid_d;

  // request payload held for the scan
  logic [COORD_W-1:0] row_q, col_q;
  logic               trans_q;
  logic               res_q;
  logic               out_vis_q;

  // fsm decodes
  logic in_ready;
  logic scanning;
  logic finishing;

  logic             accept;
  logic             done;
  logic             out_load;
  logic [CNT_W-1:0] base_comm, base_tot;
  logic [COORD_W-1:0] base_cur;
  logic             beyond;
  logic             vis_calc;
  logic             append;
  token_t           launch;
  token_t           sel_tok;
  wr_t              wr;

  token_t tok [INTERVAL_DEPTH];

  // ---------------------------------------------------------------- chain
  // the query enters stage 0 on the accept edge and moves one stage a cycle;
  // once it reaches stage n-1, that stage holds the flags over intervals 0..n-1
  assign launch = '{row: row_i, col: column_i, sb: 1'b0, eb: 1'b0, cb: 1'b0};

  for (genvar g = 0; g < INTERVAL_DEPTH; g++) begin : g_chain
    token_t tin;
    if (g == 0) begin : g_head
      assign tin = launch;
    end else begin : g_link
      assign tin = tok[g-1];
    end
    svo_cell u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .wr_i   (wr),
      .tok_i  (tin),
      .tok_o  (tok[g])
    );
  end

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    scanning  = 1'b0;
    finishing = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready  = 1'b1;
      ST_SCAN:   scanning  = 1'b1;
      ST_FINISH: finishing = 1'b1;
      default:   in_ready  = 1'b0;
    endcase
  end

  assign in_ready_o = in_ready;
  assign accept     = in_valid_i && in_ready;
  assign done       = cnt_q >= lim_q;
  assign out_load   = finishing && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------- decide
  always_comb begin
    // octant start clears intervals before the cell is handled
    base_comm = octant_start_i ? '0 : comm_q;
    base_tot  = octant_start_i ? '0 : total_q;
    base_cur  = octant_start_i ? row_i : cur_q;
    beyond    = {28'd0, row_i} >= 32'(MAX_RADIUS);

    // flags after the last committed interval; none when the query must pass none
    sel_tok = tok[lim_q[IDX_W-1:0] - IDX_W'(1)];
    if (lim_q == '0) begin
      sel_tok.sb = 1'b0;
      sel_tok.eb = 1'b0;
      sel_tok.cb = 1'b0;
    end

    if (force_q) begin
      vis_calc = fvis_q;
    end else if (trans_q) begin
      vis_calc = !(sel_tok.cb || (sel_tok.sb && sel_tok.eb));
    end else begin
      vis_calc = !(sel_tok.cb && sel_tok.sb && sel_tok.eb);
    end

    // visible opaque cell casts a new obstruction, dropped when full
    append = !force_q && vis_calc && !trans_q && (total_q < DepthCnt);

    wr.en    = scanning && done && append;
    wr.idx   = total_q[IDX_W-1:0];
    wr.entry = '{row: row_q, col: col_q};
  end

  always_comb begin
    comm_d      = comm_q;
    total_d     = total_q;
    lim_d       = lim_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    force_d     = force_q;
    fvis_d      = fvis_q;
    out_valid_d = out_valid_q;

    if (accept) begin
      total_d = base_tot;
      cnt_d   = CNT_W'(1);
      if (beyond) begin
        // outside radius: not visible, state untouched apart from the clear
        comm_d  = base_comm;
        cur_d   = base_cur;
        force_d = 1'b1;
        fvis_d  = 1'b0;
        lim_d   = '0;
      end else begin
        // a new row makes every pending interval effective
        comm_d  = (row_i != base_cur) ? base_tot : base_comm;
        cur_d   = row_i;
        force_d = (row_i == '0);  // origin is always seen
        fvis_d  = 1'b1;
        lim_d   = (row_i == '0) ? '0 : ((row_i != base_cur) ? base_tot : base_comm);
      end
    end

    if (scanning && !done) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (wr.en) begin
      total_d = total_q + CNT_W'(1);
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      comm_q      <= '0;
      total_q     <= '0;
      lim_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      force_q     <= 1'b0;
      fvis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      comm_q      <= comm_d;
      total_q     <= total_d;
      lim_q       <= lim_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      force_q     <= force_d;
      fvis_q      <= fvis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= row_i;
      col_q   <= column_i;
      trans_q <= transparent_i;
    end
    if (scanning && done) begin
      res_q <= vis_calc;
    end
    if (out_load) begin
      out_vis_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;

`ifndef SYNTH
  a_comm_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comm_q <= total_q)
    else $error("committed interval count above written count");

  a_total_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= DepthCnt)
    else $error("interval count beyond store depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= lim_q) || (lim_q == '0))
    else $error("query walked past the committed intervals");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q >= lim_q) |=> (state_q == ST_FINISH))
    else $error("scan did not hand off its result");

  a_write_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ST_SCAN) && !trans_q && !force_q)
    else $error("interval written outside the end of an opaque scan");
`endif

endmodule

// ===== design/svo_cell.sv =====
// one stage of the interval chain: holds one obstruction and tests the passing query
module svo_cell import svo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  wr_t              wr_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  entry_t     entry_q;
  token_t     tok_q;
  token_t     tok_d;
  logic [4:0] rp1;
  logic [5:0] den;
  logic [5:0] num_s;

  // angles over the common denominator 2*(row+1)
  always_comb begin
    rp1   = {1'b0, tok_i.row} + 5'd1;
    den   = {rp1, 1'b0};
    num_s = {1'b0, tok_i.col, 1'b0};
    tok_d     = tok_i;
    tok_d.sb  = tok_i.sb | in_span(num_s, den, entry_q.col, entry_q.row);
    tok_d.eb  = tok_i.eb | in_span(num_s + 6'd2, den, entry_q.col, entry_q.row);
    tok_d.cb  = tok_i.cb | in_span(num_s + 6'd1, den, entry_q.col, entry_q.row);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      entry_q <= wr_i.entry;
    end
  end

  // flags are don't-care until a query reaches this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
